// ----- hw/rtl/dawn_dusk_led_dimmer_thermal_cutoff_defines.svh -----
// assertion macros shared by the dimmer rtl
`ifndef DAWN_DUSK_LED_DIMMER_THERMAL_CUTOFF_DEFINES_SVH
`define DAWN_DUSK_LED_DIMMER_THERMAL_CUTOFF_DEFINES_SVH

`ifndef SYNTHESIS
`define DDLD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DDLD_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DDLD_ASSERT(lbl, clk, rst_n, prop, msg)
`define DDLD_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/ddld_pkg.sv -----
`timescale 1ns / 1ps

package ddld_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_LOAD,
        ST_DIV,
        ST_RND,
        ST_DONE
    } state_t;

    localparam logic [2:0] CFG_TEMP_LIMIT     = 3'd0;
    localparam logic [2:0] CFG_TEMP_MARGIN    = 3'd1;
    localparam logic [2:0] CFG_RAMP_SECONDS   = 3'd2;
    localparam logic [2:0] CFG_SUNRISE_MINUTE = 3'd3;
    localparam logic [2:0] CFG_SUNSET_MINUTE  = 3'd4;

    localparam logic signed [7:0] RST_TEMP_LIMIT     = 8'sd1;
    localparam logic [6:0]        RST_TEMP_MARGIN    = 7'd0;
    localparam logic [14:0]       RST_RAMP_SECONDS   = 15'd1800;
    localparam logic [10:0]       RST_SUNRISE_MINUTE = 11'd360;
    localparam logic [10:0]       RST_SUNSET_MINUTE  = 11'd1080;

    localparam logic [5:0] SEC_PER_MIN   = 6'd60;
    localparam logic [7:0] FULL_LEVEL    = 8'd255;
    localparam logic [6:0] ROUND_SCALE   = 7'd100;
    localparam logic [6:0] ROUND_UP_RISE = 7'd51;
    localparam logic [6:0] ROUND_UP_FALL = 7'd49;
    localparam logic [2:0] DIV_LAST      = 3'd7;

endpackage

// ----- hw/rtl/dawn_dusk_led_dimmer_thermal_cutoff.sv -----
`timescale 1ns / 1ps
// Dawn/dusk LED dimmer with thermal cutoff.
// Input channel s_*: one transfer per tick carries time_of_day (seconds) and
// temperature. Output channel m_*: one transfer per tick carries pwm_level,
// fan_on and light_enabled as they stand after that tick.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 limit,
// 1 margin, 2 ramp seconds, 3 sunrise minute, 4 sunset minute); write only
// while the block is idle.
// Outside the ramps the level is set by the window compare; inside a ramp,
// an 8-step restoring divider produces one quotient bit per cycle from
// 255*elapsed and the ramp length.
// Only one tick is processed at a time; s_tready rises again once the result
// sits in the output register.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// light enable and fan flag, and empties the output register.
// When the receiver stalls, the result holds in the output register, one
// further tick may be accepted and processed, and then waits until the
// output register is free.
`include "dawn_dusk_led_dimmer_thermal_cutoff_defines.svh"

module dawn_dusk_led_dimmer_thermal_cutoff (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [16:0] time_of_day, [24:17] temperature
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] pwm_level, [8] fan_on, [9] light_enabled
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [14:0] cfg_wdata
);

    // configuration
    logic signed [7:0] temp_limit_reg;
    logic [6:0]        temp_margin_reg;
    logic [14:0]       ramp_seconds_reg;
    logic [10:0]       sunrise_minute_reg;
    logic [10:0]       sunset_minute_reg;

    // control state
    ddld_pkg::state_t state_reg, state_next;
    logic enabled_reg;
    logic fan_reg;
    logic m_valid_reg;
    logic [2:0] div_cnt_reg;

    // payload
    logic [16:0] s_reg;
    logic [16:0] a_reg;
    logic [16:0] b_reg;
    logic        hot_reg;
    logic        cool_reg;
    logic [14:0] e_reg;
    logic        fall_reg;
    logic [22:0] div_rem_reg;
    logic [22:0] div_dsr_reg;
    logic [7:0]  div_q_reg;
    logic [7:0]  level_reg;
    logic [15:0] m_data_reg;

    // control outputs of the sequencer
    logic in_xfer;
    logic out_load;
    logic cmp_go_div;

    // input fields and hysteresis
    logic [16:0]       in_time;
    logic signed [7:0] in_temp;
    logic signed [8:0] temp_sum;
    logic              in_hot;
    logic              in_cool;

    assign in_time  = s_tdata[16:0];
    assign in_temp  = $signed(s_tdata[24:17]);
    assign temp_sum = 9'(in_temp) + $signed({2'b00, temp_margin_reg});
    assign in_hot   = in_temp >= temp_limit_reg;
    assign in_cool  = temp_sum < 9'(temp_limit_reg);

    // window compare
    logic [17:0] a_end;
    logic [17:0] b_end;
    logic [16:0] e_rise;
    logic [16:0] e_fall;
    logic [7:0]  cmp_level;
    logic        cmp_fall;
    logic [14:0] cmp_e;
    logic        ramp_zero;

    assign a_end     = 18'(a_reg) + 18'(ramp_seconds_reg);
    assign b_end     = 18'(b_reg) + 18'(ramp_seconds_reg);
    assign e_rise    = s_reg - a_reg;
    assign e_fall    = s_reg - b_reg;
    assign ramp_zero = (ramp_seconds_reg == 15'd0);

    always_comb begin
        cmp_level  = 8'd0;
        cmp_fall   = 1'b0;
        cmp_e      = e_rise[14:0];
        cmp_go_div = 1'b0;
        priority if (!enabled_reg) begin
            cmp_level = 8'd0;
        end else if (s_reg < a_reg) begin
            cmp_level = 8'd0;
        end else if (18'(s_reg) <= a_end) begin
            cmp_e = e_rise[14:0];
            if (ramp_zero) begin
                cmp_level = ddld_pkg::FULL_LEVEL;
            end else begin
                cmp_go_div = 1'b1;
            end
        end else if (s_reg < b_reg) begin
            cmp_level = ddld_pkg::FULL_LEVEL;
        end else if (18'(s_reg) <= b_end) begin
            cmp_e    = e_fall[14:0];
            cmp_fall = 1'b1;
            if (!ramp_zero) begin
                cmp_go_div = 1'b1;
            end
        end else begin
            cmp_level = 8'd0;
        end
    end

    // divider step, one quotient bit per cycle
    logic [23:0] div_diff;
    assign div_diff = {1'b0, div_rem_reg} - {1'b0, div_dsr_reg};

    // rounding
    logic [21:0] rnd_lhs;
    logic [21:0] rnd_rise;
    logic [21:0] rnd_fall;
    logic [7:0]  fall_base;
    logic [7:0]  rnd_level;

    assign rnd_lhs   = 22'(div_rem_reg[14:0]) * 22'(ddld_pkg::ROUND_SCALE);
    assign rnd_rise  = 22'(ramp_seconds_reg) * 22'(ddld_pkg::ROUND_UP_RISE);
    assign rnd_fall  = 22'(ramp_seconds_reg) * 22'(ddld_pkg::ROUND_UP_FALL);
    assign fall_base = ddld_pkg::FULL_LEVEL - div_q_reg;

    always_comb begin
        if (fall_reg) begin
            rnd_level = fall_base;
            if (rnd_lhs > rnd_fall && fall_base != 8'd0) begin
                rnd_level = fall_base - 8'd1;
            end
        end else begin
            rnd_level = div_q_reg;
            if (rnd_lhs >= rnd_rise) begin
                rnd_level = div_q_reg + 8'd1;
            end
        end
    end

    // fan after this tick
    logic fan_new;
    always_comb begin
        priority if (hot_reg) begin
            fan_new = 1'b1;
        end else if (cool_reg) begin
            fan_new = (level_reg != 8'd0);
        end else begin
            fan_new = fan_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ddld_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ddld_pkg::ST_CMP;
                end
            end
            ddld_pkg::ST_CMP: begin
                state_next = cmp_go_div ? ddld_pkg::ST_LOAD : ddld_pkg::ST_DONE;
            end
            ddld_pkg::ST_LOAD: begin
                state_next = ddld_pkg::ST_DIV;
            end
            ddld_pkg::ST_DIV: begin
                if (div_cnt_reg == ddld_pkg::DIV_LAST) begin
                    state_next = ddld_pkg::ST_RND;
                end
            end
            ddld_pkg::ST_RND: begin
                state_next = ddld_pkg::ST_DONE;
            end
            ddld_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ddld_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ddld_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ddld_pkg::ST_IDLE: s_tready = 1'b1;
            ddld_pkg::ST_DONE: out_load = !m_valid_reg || m_tready;
            default: begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign in_xfer = s_tvalid && s_tready;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_limit_reg     <= ddld_pkg::RST_TEMP_LIMIT;
            temp_margin_reg    <= ddld_pkg::RST_TEMP_MARGIN;
            ramp_seconds_reg   <= ddld_pkg::RST_RAMP_SECONDS;
            sunrise_minute_reg <= ddld_pkg::RST_SUNRISE_MINUTE;
            sunset_minute_reg  <= ddld_pkg::RST_SUNSET_MINUTE;
            state_reg          <= ddld_pkg::ST_IDLE;
            enabled_reg        <= 1'b0;
            fan_reg            <= 1'b0;
            m_valid_reg        <= 1'b0;
            div_cnt_reg        <= 3'd0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    ddld_pkg::CFG_TEMP_LIMIT:     temp_limit_reg     <= $signed(cfg_wdata[7:0]);
                    ddld_pkg::CFG_TEMP_MARGIN:    temp_margin_reg    <= cfg_wdata[6:0];
                    ddld_pkg::CFG_RAMP_SECONDS:   ramp_seconds_reg   <= cfg_wdata;
                    ddld_pkg::CFG_SUNRISE_MINUTE: sunrise_minute_reg <= cfg_wdata[10:0];
                    ddld_pkg::CFG_SUNSET_MINUTE:  sunset_minute_reg  <= cfg_wdata[10:0];
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                if (in_hot) begin
                    enabled_reg <= 1'b0;
                end else if (in_cool) begin
                    enabled_reg <= 1'b1;
                end
            end
            if (state_reg == ddld_pkg::ST_LOAD) begin
                div_cnt_reg <= 3'd0;
            end else if (state_reg == ddld_pkg::ST_DIV) begin
                div_cnt_reg <= div_cnt_reg + 3'd1;
            end
            if (out_load) begin
                fan_reg     <= fan_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s_reg    <= in_time;
            a_reg    <= 17'(sunrise_minute_reg) * 17'(ddld_pkg::SEC_PER_MIN);
            b_reg    <= 17'(sunset_minute_reg) * 17'(ddld_pkg::SEC_PER_MIN);
            hot_reg  <= in_hot;
            cool_reg <= in_cool;
        end
        if (state_reg == ddld_pkg::ST_CMP) begin
            level_reg <= cmp_level;
            e_reg     <= cmp_e;
            fall_reg  <= cmp_fall;
        end
        if (state_reg == ddld_pkg::ST_LOAD) begin
            div_rem_reg <= {e_reg, 8'd0} - 23'(e_reg);
            div_dsr_reg <= {1'b0, ramp_seconds_reg, 7'd0};
            div_q_reg   <= 8'd0;
        end
        if (state_reg == ddld_pkg::ST_DIV) begin
            if (!div_diff[23]) begin
                div_rem_reg <= div_diff[22:0];
            end
            div_q_reg   <= {div_q_reg[6:0], !div_diff[23]};
            div_dsr_reg <= {1'b0, div_dsr_reg[22:1]};
        end
        if (state_reg == ddld_pkg::ST_RND) begin
            level_reg <= rnd_level;
        end
        if (out_load) begin
            m_data_reg <= {6'd0, enabled_reg, fan_new, level_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `DDLD_ASSERT(a_accept_starts, aclk, aresetn,
        (s_tvalid && s_tready) |=> (state_reg == ddld_pkg::ST_CMP),
        "input transfer did not start the compare step")
    `DDLD_ASSERT(a_div_rem_small, aclk, aresetn,
        (state_reg == ddld_pkg::ST_RND) |-> (div_rem_reg < 23'(ramp_seconds_reg)),
        "divider remainder not below ramp length")
    `DDLD_ASSERT(a_disabled_dark, aclk, aresetn,
        m_valid_reg |-> (m_data_reg[9] || m_data_reg[7:0] == 8'd0),
        "light level nonzero while light disabled")

endmodule
